@@ hdl/mbet_pkg.sv @@
// package for the mandelbrot escape-time unit: item, result and config types,
// register index codes and q8.24 saturating arithmetic helpers
// depends on nothing
package mbet_pkg;

  localparam int LANES_DEF    = 8;
  localparam int MAX_ITER_DEF = 1023;
  localparam int OUT_LANES    = 8;
  localparam int FRAC_BITS    = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int COUNT_W      = 10;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZ_OFS  = 3'd0,
    REG_VERT_OFS   = 3'd1,
    REG_ZOOM_SCALE = 3'd2,
    REG_PIXEL_STEP = 3'd3,
    REG_ESC_RADIUS = 3'd4,
    REG_ITER_LIMIT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] group_col;
    logic [11:0] pixel_row;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_lane0;
    logic [COUNT_W-1:0] count_lane1;
    logic [COUNT_W-1:0] count_lane2;
    logic [COUNT_W-1:0] count_lane3;
    logic [COUNT_W-1:0] count_lane4;
    logic [COUNT_W-1:0] count_lane5;
    logic [COUNT_W-1:0] count_lane6;
    logic [COUNT_W-1:0] count_lane7;
  } result_t;

  typedef struct packed {
    logic signed [31:0] horiz_ofs;
    logic signed [31:0] vert_ofs;
    logic [30:0]        zoom_scale;
    logic [30:0]        pixel_step;
    logic [30:0]        escape_radius_sq;
    logic [9:0]         iteration_limit;
  } cfg_t;

  // clamp a wide signed value into 32 bits
  function automatic logic signed [31:0] sat_wide(input logic signed [65:0] v);
    if (&v[65:31] || ~|v[65:31]) begin
      return v[31:0];
    end else if (v[65]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
    if (v[32] == v[31]) begin
      return v[31:0];
    end else if (v[32]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat_sum(s);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat_sum(s);
  endfunction

  // q8.24 product: arithmetic shift floors, then clamp
  function automatic logic signed [31:0] qmul(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p >>> FRAC_BITS;
    return sat_wide(s);
  endfunction

endpackage

@@ hdl/mbet_lane.sv @@
// one escape-time lane: maps its pixel to c, then iterates z <- z^2 + c
// each iteration takes a multiply state and an update state; depends on mbet_pkg
module mbet_lane #(
  parameter int LANE_ID  = 0,
  parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF,
  localparam int CW      = $clog2(MAX_ITER + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mbet_pkg::item_t     item_i,
  input  mbet_pkg::cfg_t      cfg_i,
  input  logic [CW-1:0]       limit_i,
  output logic                fin_o,
  output logic [CW-1:0]       count_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_OFS, S_ZOOM, S_LOAD, S_MUL, S_UPD
  } state_e;

  state_e             st_q;
  logic               fin_q;
  logic [CW-1:0]      cnt_q;
  logic signed [31:0] x_q, y_q, cx_q, cy_q;
  logic signed [65:0] p_q [3];

  logic signed [32:0] op_a [3];
  logic signed [32:0] op_b [3];
  logic signed [65:0] prod [3];
  logic [12:0]        pix_idx;
  logic signed [31:0] x2, y2, xy, r2, x_nx, y_nx;
  logic               escaped;
  logic [CW-1:0]      cnt_inc;

  assign pix_idx = 13'(item_i.group_col) + 13'(LANE_ID);

  // operand select for the three shared multipliers
  always_comb begin
    op_a[0] = {x_q[31], x_q};
    op_b[0] = {x_q[31], x_q};
    op_a[1] = {y_q[31], y_q};
    op_b[1] = {y_q[31], y_q};
    op_a[2] = {x_q[31], x_q};
    op_b[2] = {y_q[31], y_q};
    case (st_q)
      S_MAP: begin
        op_a[0] = $signed({20'd0, pix_idx});
        op_b[0] = $signed({2'b00, cfg_i.pixel_step});
        op_a[1] = $signed({21'd0, item_i.pixel_row});
        op_b[1] = $signed({2'b00, cfg_i.pixel_step});
      end
      S_ZOOM: begin
        op_b[0] = $signed({2'b00, cfg_i.zoom_scale});
        op_b[1] = $signed({2'b00, cfg_i.zoom_scale});
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = op_a[i] * op_b[i];
    end
  end

  assign x2      = mbet_pkg::qmul(p_q[0]);
  assign y2      = mbet_pkg::qmul(p_q[1]);
  assign xy      = mbet_pkg::qmul(p_q[2]);
  assign r2      = mbet_pkg::add_sat(x2, y2);
  assign escaped = r2 > $signed({1'b0, cfg_i.escape_radius_sq});
  assign x_nx    = mbet_pkg::add_sat(mbet_pkg::sub_sat(x2, y2), cx_q);
  assign y_nx    = mbet_pkg::add_sat(mbet_pkg::add_sat(xy, xy), cy_q);
  assign cnt_inc = cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      fin_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      fin_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (start_i) begin
            cnt_q <= '0;
            st_q  <= S_MAP;
          end
        end
        S_MAP: begin
          for (int i = 0; i < 3; i++) p_q[i] <= prod[i];
          st_q <= S_OFS;
        end
        S_OFS: begin
          x_q  <= mbet_pkg::sub_sat(mbet_pkg::sat_wide(p_q[0]), cfg_i.horiz_ofs);
          y_q  <= mbet_pkg::sub_sat(mbet_pkg::sat_wide(p_q[1]), cfg_i.vert_ofs);
          st_q <= S_ZOOM;
        end
        S_ZOOM: begin
          for (int i = 0; i < 3; i++) p_q[i] <= prod[i];
          st_q <= S_LOAD;
        end
        S_LOAD: begin
          cx_q <= x2;
          x_q  <= x2;
          cy_q <= y2;
          y_q  <= y2;
          if (limit_i == '0) begin
            fin_q <= 1'b1;
            st_q  <= S_IDLE;
          end else begin
            st_q <= S_MUL;
          end
        end
        S_MUL: begin
          for (int i = 0; i < 3; i++) p_q[i] <= prod[i];
          st_q <= S_UPD;
        end
        S_UPD: begin
          if (escaped) begin
            fin_q <= 1'b1;
            st_q  <= S_IDLE;
          end else begin
            cnt_q <= cnt_inc;
            x_q   <= x_nx;
            y_q   <= y_nx;
            if (cnt_inc == limit_i) begin
              fin_q <= 1'b1;
              st_q  <= S_IDLE;
            end else begin
              st_q <= S_MUL;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign fin_o   = fin_q;
  assign count_o = cnt_q;

endmodule

@@ hdl/mbet_merge.sv @@
// merging stage: collects each lane's finish and issues one result item
// once every lane is done; depends on mbet_pkg
module mbet_merge #(
  parameter int LANES    = mbet_pkg::LANES_DEF,
  parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF,
  localparam int CW      = $clog2(MAX_ITER + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [LANES-1:0]            fin_i,
  input  logic [LANES-1:0][CW-1:0]    count_i,
  output logic                        done_o,
  output mbet_pkg::result_t           result_o
);

  logic [LANES-1:0] seen_q, seen_d;
  logic             done_q;
  mbet_pkg::result_t res_q;
  logic [mbet_pkg::OUT_LANES-1:0][mbet_pkg::COUNT_W-1:0] cnt_all;

  // lanes beyond LANES report zero
  for (genvar k = 0; k < mbet_pkg::OUT_LANES; k++) begin : g_cnt
    if (k < LANES) begin : g_on
      assign cnt_all[k] = mbet_pkg::COUNT_W'(count_i[k]);
    end else begin : g_off
      assign cnt_all[k] = '0;
    end
  end

  assign seen_d = seen_q | fin_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (&seen_d) begin
        seen_q <= '0;
        done_q <= 1'b1;
      end else begin
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (&seen_d) begin
      res_q.count_lane0 <= cnt_all[0];
      res_q.count_lane1 <= cnt_all[1];
      res_q.count_lane2 <= cnt_all[2];
      res_q.count_lane3 <= cnt_all[3];
      res_q.count_lane4 <= cnt_all[4];
      res_q.count_lane5 <= cnt_all[5];
      res_q.count_lane6 <= cnt_all[6];
      res_q.count_lane7 <= cnt_all[7];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ hdl/mandelbrot_escape_time_8lane_unit.sv @@
// top level of the mandelbrot escape-time unit: config registers, item
// register, lane array and merging stage; depends on mbet_pkg, mbet_lane, mbet_merge
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+-------------------------------
//  item in   | start_i, busy_o, item_i               | taken when start_i && !busy_o
//  result    | done_o, result_o                      | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i       | written when cfg_we_i is high
//
// from accept to result strobe an item runs pixel mapping (states map, offset,
// zoom and load), then m iterations, m being the iterations run by the slowest
// lane: its count, plus one when it escaped (m is at most min(iteration_limit,
// MAX_ITER)); each iteration is three multipliers into a product register,
// then the update; the merge register then raises the result strobe
// busy_o drops the cycle after done_o; reset clears control and config state only
// results cannot be stalled; user writes config only while busy_o is low, unenforced
module mandelbrot_escape_time_8lane_unit #(
  parameter int LANES    = mbet_pkg::LANES_DEF,
  parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  mbet_pkg::item_t                 item_i,
  output logic                            done_o,
  output mbet_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_ITER + 1);

  mbet_pkg::cfg_t  cfg_q;
  mbet_pkg::item_t item_q;
  logic            busy_q;
  logic            accept;
  logic [CW-1:0]   limit;

  logic [LANES-1:0]         lane_fin;
  logic [LANES-1:0][CW-1:0] lane_cnt;

  assign accept = start_i && !busy_q;

  // iteration limit capped at what the counters can hold
  assign limit = (32'(cfg_q.iteration_limit) > MAX_ITER) ? CW'(MAX_ITER)
                                                         : CW'(cfg_q.iteration_limit);

  // config register file, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.horiz_ofs        <= '0;
      cfg_q.vert_ofs         <= '0;
      cfg_q.zoom_scale       <= 31'd16777216;
      cfg_q.pixel_step       <= 31'd65536;
      cfg_q.escape_radius_sq <= 31'd67108864;
      cfg_q.iteration_limit  <= 10'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbet_pkg::REG_HORIZ_OFS:  cfg_q.horiz_ofs        <= cfg_data_i;
        mbet_pkg::REG_VERT_OFS:   cfg_q.vert_ofs         <= cfg_data_i;
        mbet_pkg::REG_ZOOM_SCALE: cfg_q.zoom_scale       <= cfg_data_i[30:0];
        mbet_pkg::REG_PIXEL_STEP: cfg_q.pixel_step       <= cfg_data_i[30:0];
        mbet_pkg::REG_ESC_RADIUS: cfg_q.escape_radius_sq <= cfg_data_i[30:0];
        mbet_pkg::REG_ITER_LIMIT: cfg_q.iteration_limit  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // busy from accept until the merged result has been shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // item held for the mapping cycles of every lane
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // lane array, one pixel per lane
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mbet_lane #(
      .LANE_ID  (k),
      .MAX_ITER (MAX_ITER)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (accept),
      .item_i  (item_q),
      .cfg_i   (cfg_q),
      .limit_i (limit),
      .fin_o   (lane_fin[k]),
      .count_o (lane_cnt[k])
    );
  end

  mbet_merge #(
    .LANES    (LANES),
    .MAX_ITER (MAX_ITER)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fin_i    (lane_fin),
    .count_i  (lane_cnt),
    .done_o   (done_o),
    .result_o (result_o)
  );

  assign busy_o = busy_q;

endmodule

@@ hdl/mbet_checker.sv @@
// port-level checker for the mandelbrot escape-time unit, bound to the top level
// depends on mandelbrot_escape_time_8lane_unit
module mbet_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_we_i
);

  // an accepted item makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("unit not busy after item accept");

  // a result only comes while an item is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe without item in flight");

  // one result per item: busy ends right after the strobe
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("busy or strobe held after result");

  // busy only ends through a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o))
    else $error("busy dropped without result");

  // config writes land only while no item is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !busy_o)
    else $error("config written while an item is in flight");

endmodule

bind mandelbrot_escape_time_8lane_unit mbet_checker u_mbet_checker (.*);

@@ tb/tb_mandelbrot_escape_time_8lane_unit.sv @@
`timescale 1ns / 100ps
// self-checking bench for the eight-lane mandelbrot escape-time unit: predicts every
// lane count of each item in saturating q8.24 and checks it against the result strobe
// depends on mbet_pkg and mandelbrot_escape_time_8lane_unit
module tb;

  localparam int HALF_PERIOD     = 4;
  // watchdog span: ten worst-case items in a row at the largest iteration limit
  localparam int WATCHDOG_CYCLES = 10 * (2 * mbet_pkg::MAX_ITER_DEF + 5);
  localparam int REPORT_LIMIT    = 10;
  localparam longint Q_HI        = longint'(mbet_pkg::Q_MAX);
  localparam longint Q_LO        = longint'(mbet_pkg::Q_MIN);
  // register indexes with no register behind them
  localparam logic [mbet_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [mbet_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;
  localparam logic [31:0] ONE_Q  = 32'h0100_0000;
  localparam logic [31:0] FOUR_Q = 32'h0400_0000;

  // result viewed lane by lane; count_lane0 sits in the top slot
  typedef logic [mbet_pkg::OUT_LANES-1:0][mbet_pkg::COUNT_W-1:0] lane_counts_t;

  logic                            clk_i      = 1'b0;
  logic                            rst_ni     = 1'b0;
  logic                            start_i    = 1'b0;
  logic                            busy_o;
  mbet_pkg::item_t                 item_i     = '0;
  logic                            done_o;
  mbet_pkg::result_t               result_o;
  logic                            cfg_we_i   = 1'b0;
  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // bench copy of the view registers, reset values first
  mbet_pkg::cfg_t view_regs = '{horiz_ofs: '0, vert_ofs: '0, zoom_scale: 31'd16777216,
                                pixel_step: 31'd65536, escape_radius_sq: 31'd67108864,
                                iteration_limit: 10'd256};

  // lane counts still owed by the block, oldest first
  mbet_pkg::result_t expected_counts[$];

  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int reg_writes      = 0;
  int deepest         = 0;
  int stall_cycles    = 0;

  mandelbrot_escape_time_8lane_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // q8.24 predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end else if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // exact product, floor shift by the fraction width, then clamp
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp_q(p >>> mbet_pkg::FRAC_BITS);
  endfunction

  // iterations that stay inside the radius; the lane freezes at the first escape
  function automatic int escape_count(input longint cx, input longint cy, input int lim);
    longint re, im, re2, im2, mag2, re_im, radius;
    int n;
    radius = longint'(view_regs.escape_radius_sq);
    re = cx;
    im = cy;
    n = 0;
    while (n < lim) begin
      re2  = q_mul(re, re);
      im2  = q_mul(im, im);
      // a clamped magnitude still compares against the radius as 2^31-1
      mag2 = clamp_q(re2 + im2);
      if (mag2 > radius) begin
        break;
      end
      n++;
      re_im = q_mul(re, im);
      re = clamp_q(clamp_q(re2 - im2) + cx);
      im = clamp_q(clamp_q(re_im + re_im) + cy);
    end
    return n;
  endfunction

  // counts for all lanes of one pixel group under the current view
  function automatic mbet_pkg::result_t predict_group(input logic [11:0] col,
                                                      input logic [11:0] row);
    lane_counts_t counts;
    longint cx, cy, step, zoom;
    int lim, k;
    lim = int'(view_regs.iteration_limit);
    if (lim > mbet_pkg::MAX_ITER_DEF) begin
      lim = mbet_pkg::MAX_ITER_DEF;
    end
    step = longint'(view_regs.pixel_step);
    zoom = longint'(view_regs.zoom_scale);
    cy = clamp_q(longint'(row) * step);
    cy = clamp_q(cy - longint'($signed(view_regs.vert_ofs)));
    cy = q_mul(cy, zoom);
    counts = '0;
    for (k = 0; k < mbet_pkg::OUT_LANES; k++) begin
      if (k < mbet_pkg::LANES_DEF) begin
        // lanes step right from the group column, whatever its alignment
        cx = clamp_q((longint'(col) + k) * step);
        cx = clamp_q(cx - longint'($signed(view_regs.horiz_ofs)));
        cx = q_mul(cx, zoom);
        counts[mbet_pkg::OUT_LANES-1-k] = mbet_pkg::COUNT_W'(escape_count(cx, cy, lim));
      end
    end
    return mbet_pkg::result_t'(counts);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // start_i is left high after the accept so back-to-back items need no dip
  task automatic send_group(input logic [11:0] col, input logic [11:0] row);
    mbet_pkg::result_t want;
    want = predict_group(col, row);
    start_i <= 1'b1;
    item_i  <= '{group_col: col, pixel_row: row};
    do @(posedge clk_i); while (busy_o);
    expected_counts.push_back(want);
    items_sent++;
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  // hold off until every owed result is in and the block is idle again
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_counts.size() != 0 || busy_o);
  endtask

  // only called while idle; the spare cycle keeps write-enable pulses apart
  task automatic write_cfg(input logic [mbet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      mbet_pkg::REG_HORIZ_OFS:  view_regs.horiz_ofs = data;
      mbet_pkg::REG_VERT_OFS:   view_regs.vert_ofs = data;
      mbet_pkg::REG_ZOOM_SCALE: view_regs.zoom_scale = data[30:0];
      mbet_pkg::REG_PIXEL_STEP: view_regs.pixel_step = data[30:0];
      mbet_pkg::REG_ESC_RADIUS: view_regs.escape_radius_sq = data[30:0];
      mbet_pkg::REG_ITER_LIMIT: view_regs.iteration_limit = data[9:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // view left at reset: step 1/256, unit zoom, radius squared 4.0, 256 iterations
  task automatic test_reset_view();
    send_group(12'h000, 12'h000);
    send_group(12'hfff, 12'hfff);
    // group columns that are not multiples of eight
    send_group(12'h555, 12'haaa);
    send_group(12'haa9, 12'h555);
  endtask

  // real axis and a few rows through a classic view of the set
  task automatic test_view_sweep();
    settle();
    write_cfg(mbet_pkg::REG_PIXEL_STEP, 32'h0004_0000);
    write_cfg(mbet_pkg::REG_HORIZ_OFS, 32'h0200_0000);
    write_cfg(mbet_pkg::REG_VERT_OFS, 32'h0140_0000);
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, ONE_Q);
    write_cfg(mbet_pkg::REG_ESC_RADIUS, FOUR_Q);
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'd64);
    send_group(12'd0, 12'd80);
    send_group(12'd64, 12'd80);
    send_group(12'd96, 12'd80);
    send_group(12'd128, 12'd80);
    send_group(12'd152, 12'd80);
    send_group(12'd104, 12'd100);
    send_group(12'd120, 12'd121);
  endtask

  task automatic test_register_extremes();
    // zero zoom pins every point at the origin
    settle();
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'd16);
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, 32'h8000_0000);
    send_group(12'hfff, 12'hfff);
    // largest zoom and step with offsets at both rails: mapping saturates
    settle();
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, 32'hffff_ffff);
    write_cfg(mbet_pkg::REG_PIXEL_STEP, 32'hffff_ffff);
    write_cfg(mbet_pkg::REG_HORIZ_OFS, 32'h8000_0000);
    write_cfg(mbet_pkg::REG_VERT_OFS, 32'h7fff_ffff);
    send_group(12'hfff, 12'hfff);
    send_group(12'h000, 12'h000);
    // zero step: every lane lands on c = -1, a bounded cycle
    settle();
    write_cfg(mbet_pkg::REG_PIXEL_STEP, 32'h0000_0000);
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, ONE_Q);
    write_cfg(mbet_pkg::REG_HORIZ_OFS, ONE_Q);
    write_cfg(mbet_pkg::REG_VERT_OFS, 32'h0000_0000);
    send_group(12'd123, 12'd456);
    // zero radius: only the origin lane survives
    settle();
    write_cfg(mbet_pkg::REG_PIXEL_STEP, 32'h0001_0000);
    write_cfg(mbet_pkg::REG_HORIZ_OFS, 32'h0000_0000);
    write_cfg(mbet_pkg::REG_ESC_RADIUS, 32'h0000_0000);
    send_group(12'd0, 12'd0);
    // full radius: a clamped magnitude never exceeds it
    settle();
    write_cfg(mbet_pkg::REG_ESC_RADIUS, 32'hffff_ffff);
    write_cfg(mbet_pkg::REG_PIXEL_STEP, ONE_Q);
    send_group(12'hfff, 12'hfff);
    // zero limit (upper data bits set, dropped by the register width)
    settle();
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'hffff_fc00);
    send_group(12'd8, 12'd8);
    // single iteration: lanes at distance 0, 1 and 2 count, the rest do not
    settle();
    write_cfg(mbet_pkg::REG_ESC_RADIUS, FOUR_Q);
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'd1);
    send_group(12'd0, 12'd0);
    // full limit at the origin: every lane runs all 1023 iterations
    settle();
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, 32'h0000_0000);
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'h0000_03ff);
    send_group(12'hfff, 12'h000);
  endtask

  // writes to indexes with no register must leave the view alone
  task automatic test_spare_index();
    settle();
    write_cfg(mbet_pkg::REG_ITER_LIMIT, 32'd32);
    write_cfg(mbet_pkg::REG_ZOOM_SCALE, 32'h0080_0000);
    write_cfg(mbet_pkg::REG_PIXEL_STEP, 32'h0004_0000);
    write_cfg(mbet_pkg::REG_HORIZ_OFS, 32'h0140_0000);
    write_cfg(SPARE_IDX_LO, 32'hffff_ffff);
    write_cfg(SPARE_IDX_HI, $urandom);
    send_group(12'd80, 12'd0);
  endtask

  // random views: most aimed at the set boundary, some with raw register noise;
  // a few run deep limits with only a handful of items
  task automatic test_random_views(input int phases);
    int p, i, n_items, col0, row0, tx, ty;
    logic [31:0] step, zoom;
    longint xo, yo;
    bit gappy, deep;
    for (p = 0; p < phases; p++) begin
      settle();
      deep = (p % 12 == 7);
      col0 = $urandom_range(64, 4031);
      row0 = $urandom_range(64, 4031);
      if ($urandom_range(0, 5) == 0) begin
        write_cfg(mbet_pkg::REG_HORIZ_OFS, $urandom);
        write_cfg(mbet_pkg::REG_VERT_OFS, $urandom);
        write_cfg(mbet_pkg::REG_ZOOM_SCALE, $urandom);
        write_cfg(mbet_pkg::REG_PIXEL_STEP, $urandom);
        write_cfg(mbet_pkg::REG_ESC_RADIUS, $urandom);
      end else begin
        // place the anchor pixel, before the zoom, on a point in [-2, 0.5] x [-1.25, 1.25]
        step = $urandom_range(1 << 14, 1 << 18);
        zoom = ($urandom_range(0, 1) == 0) ? ONE_Q : $urandom_range(1 << 23, 1 << 25);
        tx = int'($urandom_range(0, 5 << 23)) - (4 << 23);
        ty = int'($urandom_range(0, 5 << 23)) - (5 << 22);
        xo = longint'(col0) * longint'(step) - tx;
        yo = longint'(row0) * longint'(step) - ty;
        write_cfg(mbet_pkg::REG_HORIZ_OFS, 32'(xo));
        write_cfg(mbet_pkg::REG_VERT_OFS, 32'(yo));
        write_cfg(mbet_pkg::REG_ZOOM_SCALE, zoom | ($urandom & 32'h8000_0000));
        write_cfg(mbet_pkg::REG_PIXEL_STEP, step | ($urandom & 32'h8000_0000));
        write_cfg(mbet_pkg::REG_ESC_RADIUS, ($urandom_range(0, 3) != 0) ? FOUR_Q :
                                            $urandom_range(1 << 20, 16 << 24));
      end
      write_cfg(mbet_pkg::REG_ITER_LIMIT,
                (deep ? $urandom_range(512, 1023) : $urandom_range(1, 48))
                | ($urandom & 32'hffff_fc00));
      n_items = deep ? 4 : 64;
      // the closing phases run without any sender gaps
      gappy = (p < phases - 3) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < n_items; i++) begin
        if (gappy && $urandom_range(0, 3) == 0) begin
          idle_burst();
        end
        // wait for every owed result mid-phase now and then
        if (p % 2 == 0 && p < phases - 3 && i == n_items / 2) begin
          settle();
        end
        if ($urandom_range(0, 4) != 0) begin
          send_group(12'(col0 - 64 + $urandom_range(0, 127)),
                     12'(row0 - 64 + $urandom_range(0, 127)));
        end else begin
          send_group(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  // done_o and result_o are sampled at the edge that ends their cycle
  always @(posedge clk_i) begin : check_results
    lane_counts_t got, want;
    int k;
    if (rst_ni && done_o) begin
      got = lane_counts_t'(result_o);
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %h arrived with no item outstanding", result_o);
        end
      end else begin
        want = lane_counts_t'(expected_counts.pop_front());
        for (k = 0; k < mbet_pkg::OUT_LANES; k++) begin
          if (got[mbet_pkg::OUT_LANES-1-k] !== want[mbet_pkg::OUT_LANES-1-k]) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("item %0d count_lane%0d: expected %0d, got %0d", results_checked, k,
                       want[mbet_pkg::OUT_LANES-1-k], got[mbet_pkg::OUT_LANES-1-k]);
            end
          end
          if (int'(want[mbet_pkg::OUT_LANES-1-k]) > deepest) begin
            deepest = int'(want[mbet_pkg::OUT_LANES-1-k]);
          end
        end
        results_checked++;
      end
    end
  end

  // cycles without an accepted item or a result strobe
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("no item accepted and no result for %0d cycles", stall_cycles);
      $display("[mandelbrot_escape_time_8lane_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_view_sweep();
    test_register_extremes();
    test_spare_index();
    test_random_views(30);
    settle();
    // any stray strobe would show up within one more item time
    repeat (2 * int'(view_regs.iteration_limit) + 16) @(posedge clk_i);
    $display("run covered %0d pixel groups and %0d register writes", items_sent, reg_writes);
    $display("%0d results checked, deepest lane count %0d", results_checked, deepest);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("[mandelbrot_escape_time_8lane_unit] OK");
    end else begin
      $display("[mandelbrot_escape_time_8lane_unit] ERROR");
    end
    $finish;
  end

endmodule
